// ===== rtl/mcps_pkg.sv =====
package mcps_pkg;

    // Fixed-point format and sizes of the datapath.
    localparam int FRAC_BITS      = 20;
    localparam int COS_TABLE_BITS = 10;
    localparam int CORDIC_STEPS   = 30;
    localparam int CORDIC_CNT_W   = $clog2(CORDIC_STEPS);
    localparam longint ONE_L      = 64'sd1 <<< FRAC_BITS;

    // Field widths.
    localparam int POS_W   = 24;
    localparam int VEL_W   = 22;
    localparam int OBS_W   = 23;
    localparam int SUM_W   = 21;
    localparam int VMID_W  = 25;
    localparam int CLAMP_W = POS_W + 2;

    // Serial multiplier: signed 32-bit multiplicand, unsigned 32-bit multiplier.
    localparam int MUL_W     = 32;
    localparam int PROD_W    = 2 * MUL_W;
    localparam int MUL_CNT_W = $clog2(MUL_W);

    // CORDIC word and phase arithmetic.
    localparam int CORDIC_W    = 34;
    localparam int PHASE_SHIFT = 32 + FRAC_BITS - COS_TABLE_BITS;
    localparam int PHASE_W     = PHASE_SHIFT + COS_TABLE_BITS;
    localparam int COS_SHIFT   = 30 - FRAC_BITS;

    localparam logic [MUL_W-1:0] INV_TWO_PI_Q32 = 32'd683565276;
    localparam logic [MUL_W-1:0] HALF_PI_Q30    = 32'd1686629713;
    localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;

    localparam logic [31:0] ATAN_Q30 [CORDIC_STEPS] = '{
        32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
        32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
        32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
        32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
        32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F, 32'h0000003F,
        32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002
    };

    // Observation divider.
    localparam int DIV_NUM_W = 29;
    localparam int DIV_W     = 30;
    localparam int DIV_CNT_W = $clog2(DIV_W);
    localparam int DIVISOR_W = 4;
    localparam logic [DIVISOR_W-1:0] DIV_POS = 4'd9;
    localparam logic [DIVISOR_W-1:0] DIV_VEL = 4'd7;
    localparam logic [DIV_W-1:0] OBS_LIMIT = DIV_W'(2 * ONE_L);

    // Friction factors, each fraction rounded to nearest at FRAC_BITS.
    localparam logic [MUL_W-1:0] FACTOR_LOW  = MUL_W'((99 * ONE_L + 50) / 100);
    localparam logic [MUL_W-1:0] FACTOR_MED  = MUL_W'((197 * ONE_L + 100) / 200);
    localparam logic [MUL_W-1:0] FACTOR_HIGH = MUL_W'((39 * ONE_L + 20) / 40);

    // Register reset values.
    localparam logic [1:0]              FRICTION_RESET = 2'd0;
    localparam logic [15:0]             PUSH_RESET  = 16'((ONE_L + 500) / 1000);
    localparam logic [15:0]             GAIN_RESET  = 16'((ONE_L + 200) / 400);
    localparam logic [20:0]             SPEED_RESET = 21'((7 * ONE_L + 50) / 100);
    localparam logic signed [22:0]      LEFT_RESET  = 23'(-((12 * ONE_L + 5) / 10));
    localparam logic [22:0]             RIGHT_RESET = 23'((6 * ONE_L + 5) / 10);
    localparam logic signed [23:0]      GOAL_RESET  = 24'(ONE_L / 2);
    localparam logic signed [SUM_W-1:0] SUM_FLOOR   = -21'sd1048575;

    // Register map.
    typedef enum logic [2:0] {
        REG_FRICTION = 3'd0,
        REG_PUSH     = 3'd1,
        REG_GAIN     = 3'd2,
        REG_SPEED    = 3'd3,
        REG_LEFT     = 3'd4,
        REG_RIGHT    = 3'd5,
        REG_GOAL     = 3'd6
    } reg_index_t;

    // Request, action and friction codes.
    localparam logic       REQ_STEP    = 1'b0;
    localparam logic       REQ_RESTART = 1'b1;
    localparam logic [1:0] ACT_LEFT    = 2'd0;
    localparam logic [1:0] ACT_RIGHT   = 2'd2;
    localparam logic [1:0] FRIC_NONE   = 2'd0;
    localparam logic [1:0] FRIC_LOW    = 2'd1;
    localparam logic [1:0] FRIC_MED    = 2'd2;
    localparam logic [1:0] FRIC_HIGH   = 2'd3;

    function automatic logic [MUL_W-1:0] friction_factor(input logic [1:0] mode);
        logic [MUL_W-1:0] f;
        unique case (mode)
            FRIC_LOW:  f = FACTOR_LOW;
            FRIC_MED:  f = FACTOR_MED;
            FRIC_HIGH: f = FACTOR_HIGH;
            default:   f = MUL_W'(ONE_L);
        endcase
        return f;
    endfunction

endpackage

// ===== rtl/mcps_if.sv =====
// Request channel.
interface mcps_req_if;
    logic              valid;
    logic              ready;
    logic              req_type;
    logic [1:0]        action;
    logic signed [23:0] start_position;

    modport source (output valid, req_type, action, start_position, input ready);
    modport sink   (input valid, req_type, action, start_position, output ready);
endinterface

// Result channel.
interface mcps_res_if;
    logic               valid;
    logic               ready;
    logic signed [23:0] position_out;
    logic signed [21:0] velocity_out;
    logic signed [22:0] norm_position;
    logic signed [22:0] norm_velocity;
    logic signed [0:0]  reward;
    logic signed [20:0] reward_total;
    logic               done_res;
    logic               step_error;

    modport source (output valid, position_out, velocity_out, norm_position, norm_velocity,
                    reward, reward_total, done_res, step_error, input ready);
    modport sink   (input valid, position_out, velocity_out, norm_position, norm_velocity,
                    reward, reward_total, done_res, step_error, output ready);
endinterface

// ===== rtl/mcps_serial_mul.sv =====
module mcps_serial_mul (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic signed [mcps_pkg::MUL_W-1:0]   a,
    input  logic [mcps_pkg::MUL_W-1:0]          b,
    output logic                                busy,
    output logic signed [mcps_pkg::PROD_W-1:0]  product
);

    logic signed [mcps_pkg::MUL_W-1:0] a_reg, a_next;
    logic [mcps_pkg::PROD_W:0]         p_reg, p_next;
    logic [mcps_pkg::MUL_CNT_W-1:0]    cnt_reg, cnt_next;
    logic                              busy_reg, busy_next;
    logic [mcps_pkg::MUL_W:0]          sum;

    // One multiplier bit per cycle: add the multiplicand into the upper half,
    // then shift the whole product register right by one.
    always_comb begin
        sum = p_reg[mcps_pkg::PROD_W:mcps_pkg::MUL_W]
            + (p_reg[0] ? {a_reg[mcps_pkg::MUL_W-1], a_reg} : (mcps_pkg::MUL_W + 1)'(0));
        a_next    = a_reg;
        p_next    = p_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            a_next    = a;
            p_next    = {(mcps_pkg::MUL_W + 1)'(0), b};
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            p_next   = {sum[mcps_pkg::MUL_W], sum, p_reg[mcps_pkg::MUL_W-1:1]};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == mcps_pkg::MUL_CNT_W'(mcps_pkg::MUL_W - 1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        p_reg <= p_next;
    end

    assign busy    = busy_reg;
    assign product = p_reg[mcps_pkg::PROD_W-1:0];

endmodule

// ===== rtl/mcps_cordic.sv =====
module mcps_cordic (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic signed [mcps_pkg::CORDIC_W-1:0] z0,
    output logic                                 busy,
    output logic signed [mcps_pkg::CORDIC_W-1:0] x,
    output logic signed [mcps_pkg::CORDIC_W-1:0] y
);

    logic signed [mcps_pkg::CORDIC_W-1:0] x_reg, x_next;
    logic signed [mcps_pkg::CORDIC_W-1:0] y_reg, y_next;
    logic signed [mcps_pkg::CORDIC_W-1:0] z_reg, z_next;
    logic [mcps_pkg::CORDIC_CNT_W-1:0]    i_reg, i_next;
    logic                                 busy_reg, busy_next;
    logic signed [mcps_pkg::CORDIC_W-1:0] dx, dy, angle;

    // One rotation per cycle, steered by the sign of the residual angle.
    always_comb begin
        dx    = y_reg >>> i_reg;
        dy    = x_reg >>> i_reg;
        angle = mcps_pkg::CORDIC_W'($signed({1'b0, mcps_pkg::ATAN_Q30[i_reg]}));
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        i_next    = i_reg;
        busy_next = busy_reg;
        if (start)
        begin
            x_next    = mcps_pkg::CORDIC_GAIN_Q30;
            y_next    = '0;
            z_next    = z0;
            i_next    = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!z_reg[mcps_pkg::CORDIC_W-1])
            begin
                x_next = x_reg - dx;
                y_next = y_reg + dy;
                z_next = z_reg - angle;
            end
            else
            begin
                x_next = x_reg + dx;
                y_next = y_reg - dy;
                z_next = z_reg + angle;
            end
            i_next = i_reg + 1'b1;
            if (i_reg == mcps_pkg::CORDIC_CNT_W'(mcps_pkg::CORDIC_STEPS - 1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            i_reg    <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            i_reg    <= i_next;
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
    end

    assign busy = busy_reg;
    assign x    = x_reg;
    assign y    = y_reg;

endmodule

// ===== rtl/mcps_obs_div.sv =====
module mcps_obs_div (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    input  logic signed [mcps_pkg::DIV_NUM_W-1:0] num,
    input  logic [mcps_pkg::DIVISOR_W-1:0]        divisor,
    output logic                                  busy,
    output logic signed [mcps_pkg::OBS_W-1:0]     result
);

    logic [mcps_pkg::DIV_W-1:0]        q_reg, q_next;
    logic [mcps_pkg::DIVISOR_W-1:0]    rem_reg, rem_next;
    logic [mcps_pkg::DIVISOR_W-1:0]    d_reg, d_next;
    logic                              neg_reg, neg_next;
    logic [mcps_pkg::DIV_CNT_W-1:0]    cnt_reg, cnt_next;
    logic                              busy_reg, busy_next;
    logic [mcps_pkg::DIV_W-1:0]        num_ext, mag;
    logic [mcps_pkg::DIVISOR_W:0]      trial;
    logic                              qbit;
    logic [mcps_pkg::DIV_W-1:0]        sat;
    logic signed [mcps_pkg::OBS_W-1:0] sat_s;

    // Restoring division by a small constant, one quotient bit per cycle.
    // The magnitude is pre-biased by half the divisor, so the quotient is
    // rounded half away from zero once the sign is put back.
    always_comb begin
        num_ext = {num[mcps_pkg::DIV_NUM_W-1], num};
        mag     = num_ext[mcps_pkg::DIV_W-1] ? (~num_ext + 1'b1) : num_ext;
        trial   = {rem_reg, q_reg[mcps_pkg::DIV_W-1]};
        qbit    = (trial >= {1'b0, d_reg});
        q_next    = q_reg;
        rem_next  = rem_reg;
        d_next    = d_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            q_next    = mag + mcps_pkg::DIV_W'(divisor >> 1);
            rem_next  = '0;
            d_next    = divisor;
            neg_next  = num[mcps_pkg::DIV_NUM_W-1];
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = qbit ? mcps_pkg::DIVISOR_W'(trial - {1'b0, d_reg})
                            : trial[mcps_pkg::DIVISOR_W-1:0];
            q_next   = {q_reg[mcps_pkg::DIV_W-2:0], qbit};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == mcps_pkg::DIV_CNT_W'(mcps_pkg::DIV_W - 1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    // Saturate to plus or minus 2.0 and restore the sign.
    always_comb begin
        sat    = (q_reg > mcps_pkg::OBS_LIMIT) ? mcps_pkg::OBS_LIMIT : q_reg;
        sat_s  = sat[mcps_pkg::OBS_W-1:0];
        result = neg_reg ? -sat_s : sat_s;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
        d_reg   <= d_next;
        neg_reg <= neg_next;
    end

    assign busy = busy_reg;

endmodule

// ===== rtl/mountain_car_physics_step.sv =====
// Mountain-car step engine in signed Q4.20, one item at a time.
// A step beat runs up to four bit-serial multiplies (three with friction off), a 30-step
// CORDIC and the two observation divides, which run side by side.
// A restart or a refused step goes straight to the divides.
// A new item is taken after the result is registered; the result waits in an output
// register. Reset clears car state and episode and loads the reset configuration.
module mountain_car_physics_step (
    input  logic        clk,
    input  logic        rst_n,
    mcps_req_if.sink    req,
    mcps_res_if.source  res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    typedef enum logic [8:0] {
        ST_IDLE      = 9'b000000001,
        ST_PHASE     = 9'b000000010,
        ST_THETA     = 9'b000000100,
        ST_CORDIC    = 9'b000001000,
        ST_GRAV      = 9'b000010000,
        ST_FRIC      = 9'b000100000,
        ST_UPDATE    = 9'b001000000,
        ST_OBS_START = 9'b010000000,
        ST_OBS       = 9'b100000000
    } state_t;

    // Round a product back to FRAC_BITS; the rounded value fits VMID_W bits.
    function automatic logic signed [mcps_pkg::VMID_W-1:0] round_frac(
        input logic [mcps_pkg::PROD_W-1:0] p);
        logic [mcps_pkg::VMID_W+mcps_pkg::FRAC_BITS-1:0] s;
        s = p[mcps_pkg::VMID_W+mcps_pkg::FRAC_BITS-1:0]
          + ((mcps_pkg::VMID_W + mcps_pkg::FRAC_BITS)'(1) << (mcps_pkg::FRAC_BITS - 1));
        return s[mcps_pkg::VMID_W+mcps_pkg::FRAC_BITS-1:mcps_pkg::FRAC_BITS];
    endfunction

    // Clamp to the left limit first, then to the right limit.
    function automatic logic signed [mcps_pkg::POS_W-1:0] clamp_pos(
        input logic signed [mcps_pkg::CLAMP_W-1:0] v,
        input logic signed [mcps_pkg::CLAMP_W-1:0] lo,
        input logic signed [mcps_pkg::CLAMP_W-1:0] hi);
        logic signed [mcps_pkg::CLAMP_W-1:0] t;
        t = v;
        if (t < lo)
        begin
            t = lo;
        end
        if (t > hi)
        begin
            t = hi;
        end
        return t[mcps_pkg::POS_W-1:0];
    endfunction

    // Configuration registers.
    logic [1:0]         friction_reg;
    logic [15:0]        push_reg;
    logic [15:0]        gain_reg;
    logic [20:0]        speed_reg;
    logic signed [22:0] left_reg;
    logic [22:0]        right_reg;
    logic signed [23:0] goal_reg;
    logic               cfg_write;

    // Control and state.
    state_t                                state_reg, state_next;
    logic signed [mcps_pkg::POS_W-1:0]     pos_reg, pos_next;
    logic signed [mcps_pkg::VEL_W-1:0]     vel_reg, vel_next;
    logic                                  done_reg, done_next;
    logic signed [mcps_pkg::SUM_W-1:0]     sum_reg, sum_next;
    logic                                  reward_reg, reward_next;
    logic                                  err_reg, err_next;
    logic [1:0]                            act_reg, act_next;
    logic [1:0]                            quad_reg, quad_next;
    logic signed [mcps_pkg::VMID_W-1:0]    vmid_reg, vmid_next;
    logic                                  out_valid_reg, out_valid_next;

    // Output register.
    logic signed [mcps_pkg::POS_W-1:0]     pos_out_reg;
    logic signed [mcps_pkg::VEL_W-1:0]     vel_out_reg;
    logic signed [mcps_pkg::OBS_W-1:0]     npos_out_reg;
    logic signed [mcps_pkg::OBS_W-1:0]     nvel_out_reg;
    logic                                  reward_out_reg;
    logic signed [mcps_pkg::SUM_W-1:0]     sum_out_reg;
    logic                                  done_out_reg;
    logic                                  err_out_reg;
    logic                                  out_load;

    // Arithmetic units; the multiplier is shared by every product.
    logic                                  mul_start, mul_busy;
    logic signed [mcps_pkg::MUL_W-1:0]     mul_a;
    logic [mcps_pkg::MUL_W-1:0]            mul_b;
    logic signed [mcps_pkg::PROD_W-1:0]    mul_product;
    logic                                  cordic_start, cordic_busy;
    logic signed [mcps_pkg::CORDIC_W-1:0]  cordic_z0, cordic_x, cordic_y;
    logic                                  div_start, div_p_busy, div_v_busy;
    logic signed [mcps_pkg::DIV_NUM_W-1:0] num_p, num_v, pos_div, vel_div;
    logic signed [mcps_pkg::OBS_W-1:0]     npos, nvel;

    // Datapath terms.
    logic signed [mcps_pkg::MUL_W-1:0]     pos32, three_p;
    logic [mcps_pkg::PHASE_W-1:0]          phase_sum;
    logic [mcps_pkg::COS_TABLE_BITS-1:0]   phase_k;
    logic signed [mcps_pkg::CORDIC_W-1:0]  cos_sel, cos_rnd;
    logic signed [mcps_pkg::VMID_W-1:0]    vel_ext, push_ext, v1, v2, vlim, vc;
    logic signed [mcps_pkg::CLAMP_W-1:0]   left_ext, right_ext, goal_ext;
    logic signed [mcps_pkg::POS_W-1:0]     pnew, pstart;
    logic                                  done_new;

    // Configuration port: writes land in the access phase.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            friction_reg <= mcps_pkg::FRICTION_RESET;
            push_reg     <= mcps_pkg::PUSH_RESET;
            gain_reg     <= mcps_pkg::GAIN_RESET;
            speed_reg    <= mcps_pkg::SPEED_RESET;
            left_reg     <= mcps_pkg::LEFT_RESET;
            right_reg    <= mcps_pkg::RIGHT_RESET;
            goal_reg     <= mcps_pkg::GOAL_RESET;
        end
        else if (cfg_write)
        begin
            unique case (paddr[4:2])
                mcps_pkg::REG_FRICTION: friction_reg <= pwdata[1:0];
                mcps_pkg::REG_PUSH:     push_reg     <= pwdata[15:0];
                mcps_pkg::REG_GAIN:     gain_reg     <= pwdata[15:0];
                mcps_pkg::REG_SPEED:    speed_reg    <= pwdata[20:0];
                mcps_pkg::REG_LEFT:     left_reg     <= pwdata[22:0];
                mcps_pkg::REG_RIGHT:    right_reg    <= pwdata[22:0];
                mcps_pkg::REG_GOAL:     goal_reg     <= pwdata[23:0];
                default:                ;
            endcase
        end
    end

    // Register read-back.
    always_comb begin
        unique case (paddr[4:2])
            mcps_pkg::REG_FRICTION: prdata = {30'd0, friction_reg};
            mcps_pkg::REG_PUSH:     prdata = {16'd0, push_reg};
            mcps_pkg::REG_GAIN:     prdata = {16'd0, gain_reg};
            mcps_pkg::REG_SPEED:    prdata = {11'd0, speed_reg};
            mcps_pkg::REG_LEFT:     prdata = 32'(left_reg);
            mcps_pkg::REG_RIGHT:    prdata = {9'd0, right_reg};
            mcps_pkg::REG_GOAL:     prdata = 32'(goal_reg);
            default:                prdata = '0;
        endcase
    end

    mcps_serial_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .busy    (mul_busy),
        .product (mul_product)
    );

    mcps_cordic u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cordic_start),
        .z0    (cordic_z0),
        .busy  (cordic_busy),
        .x     (cordic_x),
        .y     (cordic_y)
    );

    mcps_obs_div u_div_pos (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start),
        .num     (num_p),
        .divisor (mcps_pkg::DIV_POS),
        .busy    (div_p_busy),
        .result  (npos)
    );

    mcps_obs_div u_div_vel (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start),
        .num     (num_v),
        .divisor (mcps_pkg::DIV_VEL),
        .busy    (div_v_busy),
        .result  (nvel)
    );

    // Phase, cosine and velocity terms.
    always_comb begin
        pos32     = mcps_pkg::MUL_W'(pos_reg);
        three_p   = (pos32 <<< 1) + pos32;
        phase_sum = mul_product[mcps_pkg::PHASE_W-1:0]
                  + (mcps_pkg::PHASE_W'(1) << (mcps_pkg::PHASE_SHIFT - 1));
        phase_k   = phase_sum[mcps_pkg::PHASE_W-1:mcps_pkg::PHASE_SHIFT];
        cordic_z0 = mul_product[mcps_pkg::CORDIC_W+mcps_pkg::COS_TABLE_BITS-3:
                                mcps_pkg::COS_TABLE_BITS-2];

        unique case (quad_reg)
            2'd0:    cos_sel = cordic_x;
            2'd1:    cos_sel = -cordic_y;
            2'd2:    cos_sel = -cordic_x;
            default: cos_sel = cordic_y;
        endcase
        cos_rnd = (cos_sel + (mcps_pkg::CORDIC_W'(1) <<< (mcps_pkg::COS_SHIFT - 1)))
                  >>> mcps_pkg::COS_SHIFT;

        vel_ext  = mcps_pkg::VMID_W'(vel_reg);
        push_ext = mcps_pkg::VMID_W'($signed({1'b0, push_reg}));
        if (act_reg == mcps_pkg::ACT_LEFT)
        begin
            v1 = vel_ext - push_ext;
        end
        else if (act_reg == mcps_pkg::ACT_RIGHT)
        begin
            v1 = vel_ext + push_ext;
        end
        else
        begin
            v1 = vel_ext;
        end
        v2 = v1 - round_frac(mul_product);
    end

    // Speed clamp, position update, goal test and restart position clamp.
    always_comb begin
        left_ext  = mcps_pkg::CLAMP_W'(left_reg);
        right_ext = mcps_pkg::CLAMP_W'($signed({1'b0, right_reg}));
        goal_ext  = mcps_pkg::CLAMP_W'(goal_reg);
        vlim      = mcps_pkg::VMID_W'($signed({1'b0, speed_reg}));
        vc        = vmid_reg;
        if (vc < -vlim)
        begin
            vc = -vlim;
        end
        if (vc > vlim)
        begin
            vc = vlim;
        end
        pnew     = clamp_pos(mcps_pkg::CLAMP_W'(pos_reg) + mcps_pkg::CLAMP_W'(vc),
                             left_ext, right_ext);
        done_new = (mcps_pkg::CLAMP_W'(pnew) >= goal_ext);
        pstart   = clamp_pos(mcps_pkg::CLAMP_W'(req.start_position), left_ext, right_ext);
    end

    // Observation numerators: 10*p + 3.0 and 100*v.
    always_comb begin
        pos_div = mcps_pkg::DIV_NUM_W'(pos_reg);
        vel_div = mcps_pkg::DIV_NUM_W'(vel_reg);
        num_p   = (pos_div <<< 3) + (pos_div <<< 1)
                + mcps_pkg::DIV_NUM_W'(64'sd3 <<< mcps_pkg::FRAC_BITS);
        num_v   = (vel_div <<< 6) + (vel_div <<< 5) + (vel_div <<< 2);
    end

    // Sequencer.
    always_comb begin
        state_next   = state_reg;
        pos_next     = pos_reg;
        vel_next     = vel_reg;
        done_next    = done_reg;
        sum_next     = sum_reg;
        reward_next  = reward_reg;
        err_next     = err_reg;
        act_next     = act_reg;
        quad_next    = quad_reg;
        vmid_next    = vmid_reg;
        mul_start    = 1'b0;
        mul_a        = '0;
        mul_b        = '0;
        cordic_start = 1'b0;
        div_start    = 1'b0;
        out_load     = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    priority if (req.req_type == mcps_pkg::REQ_RESTART)
                    begin
                        pos_next    = pstart;
                        vel_next    = '0;
                        done_next   = 1'b0;
                        sum_next    = '0;
                        reward_next = 1'b0;
                        err_next    = 1'b0;
                        state_next  = ST_OBS_START;
                    end
                    else if (done_reg)
                    begin
                        reward_next = 1'b0;
                        err_next    = 1'b1;
                        state_next  = ST_OBS_START;
                    end
                    else
                    begin
                        act_next   = req.action;
                        err_next   = 1'b0;
                        mul_start  = 1'b1;
                        mul_a      = three_p;
                        mul_b      = mcps_pkg::INV_TWO_PI_Q32;
                        state_next = ST_PHASE;
                    end
                end
            end
            ST_PHASE:
            begin
                if (!mul_busy)
                begin
                    quad_next  = phase_k[mcps_pkg::COS_TABLE_BITS-1:mcps_pkg::COS_TABLE_BITS-2];
                    mul_start  = 1'b1;
                    mul_a      = $signed(mcps_pkg::HALF_PI_Q30);
                    mul_b      = mcps_pkg::MUL_W'(phase_k[mcps_pkg::COS_TABLE_BITS-3:0]);
                    state_next = ST_THETA;
                end
            end
            ST_THETA:
            begin
                if (!mul_busy)
                begin
                    cordic_start = 1'b1;
                    state_next   = ST_CORDIC;
                end
            end
            ST_CORDIC:
            begin
                if (!cordic_busy)
                begin
                    mul_start  = 1'b1;
                    mul_a      = mcps_pkg::MUL_W'(cos_rnd);
                    mul_b      = mcps_pkg::MUL_W'(gain_reg);
                    state_next = ST_GRAV;
                end
            end
            ST_GRAV:
            begin
                if (!mul_busy)
                begin
                    vmid_next = v2;
                    if (friction_reg != mcps_pkg::FRIC_NONE)
                    begin
                        mul_start  = 1'b1;
                        mul_a      = mcps_pkg::MUL_W'(v2);
                        mul_b      = mcps_pkg::friction_factor(friction_reg);
                        state_next = ST_FRIC;
                    end
                    else
                    begin
                        state_next = ST_UPDATE;
                    end
                end
            end
            ST_FRIC:
            begin
                if (!mul_busy)
                begin
                    vmid_next  = round_frac(mul_product);
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                pos_next  = pnew;
                vel_next  = ((mcps_pkg::CLAMP_W'(pnew) == left_ext) && (vc < 0))
                          ? '0 : vc[mcps_pkg::VEL_W-1:0];
                done_next = done_new;
                if (!done_new)
                begin
                    reward_next = 1'b1;
                    if (sum_reg > mcps_pkg::SUM_FLOOR)
                    begin
                        sum_next = sum_reg - 1'b1;
                    end
                end
                else
                begin
                    reward_next = 1'b0;
                end
                state_next = ST_OBS_START;
            end
            ST_OBS_START:
            begin
                div_start  = 1'b1;
                state_next = ST_OBS;
            end
            ST_OBS:
            begin
                if (!div_p_busy && !div_v_busy && (!out_valid_reg || res.ready))
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Result beat handshake.
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (res.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pos_reg       <= '0;
            vel_reg       <= '0;
            done_reg      <= 1'b0;
            sum_reg       <= '0;
            reward_reg    <= 1'b0;
            err_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            vel_reg       <= vel_next;
            done_reg      <= done_next;
            sum_reg       <= sum_next;
            reward_reg    <= reward_next;
            err_reg       <= err_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Working registers and the output register.
    always_ff @(posedge clk)
    begin
        act_reg  <= act_next;
        quad_reg <= quad_next;
        vmid_reg <= vmid_next;
        if (out_load)
        begin
            pos_out_reg    <= pos_reg;
            vel_out_reg    <= vel_reg;
            npos_out_reg   <= npos;
            nvel_out_reg   <= nvel;
            reward_out_reg <= reward_reg;
            sum_out_reg    <= sum_reg;
            done_out_reg   <= done_reg;
            err_out_reg    <= err_reg;
        end
    end

    assign req.ready         = (state_reg == ST_IDLE);
    assign res.valid         = out_valid_reg;
    assign res.position_out  = pos_out_reg;
    assign res.velocity_out  = vel_out_reg;
    assign res.norm_position = npos_out_reg;
    assign res.norm_velocity = nvel_out_reg;
    assign res.reward        = reward_out_reg;
    assign res.reward_total  = sum_out_reg;
    assign res.done_res      = done_out_reg;
    assign res.step_error    = err_out_reg;

endmodule

// ===== tb/sv/mcps_checker.sv =====
`timescale 1ns / 1ps

// Watches the request, result and register channels of the step engine,
// predicts every result from its own copy of the car and configuration,
// and compares each result beat with the oldest prediction.
module mcps_checker
    import mcps_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    mcps_req_if         req,
    mcps_res_if         res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          fail_count,
    output int          pending,
    output int          steps_seen,
    output int          goals_seen,
    output int          refusals_seen
);

    typedef struct {
        logic signed [23:0] position;
        logic signed [21:0] velocity;
        logic signed [22:0] norm_pos;
        logic signed [22:0] norm_vel;
        logic signed [0:0]  reward;
        logic signed [20:0] total;
        logic               done;
        logic               refused;
    } car_result_t;

    // Configuration copy.
    logic [1:0]  cfg_friction;
    longint      cfg_push, cfg_gain, cfg_speed, cfg_left, cfg_right, cfg_goal;

    // Car state copy.
    longint      car_pos, car_vel, ep_sum;
    logic        ep_done;

    car_result_t expected_results[$];

    function automatic longint round_shift(longint v, int s);
        return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic longint div_nearest(longint n, longint d);
        return (n >= 0) ? (n + d / 2) / d : -((-n + d / 2) / d);
    endfunction

    function automatic longint bound(longint v, longint lo, longint hi);
        if (v < lo)
        begin
            v = lo;
        end
        if (v > hi)
        begin
            v = hi;
        end
        return v;
    endfunction

    // Cosine of three times the position, via the phase index and a CORDIC.
    function automatic longint cos_three(longint p);
        longint unsigned prod, k, r;
        longint z, x, y, c, dx, dy;
        int quad;
        prod = longint'(3 * p) * longint'(683565276);
        k = ((prod + (64'd1 << (PHASE_SHIFT - 1))) >> PHASE_SHIFT) & 64'd1023;
        quad = int'(k >> 8);
        r = k & 64'd255;
        z = longint'((r * 64'd1686629713) >> 8);
        x = 652032874;
        y = 0;
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x = x - dx;
                y = y + dy;
                z = z - longint'(ATAN_Q30[i]);
            end
            else
            begin
                x = x + dx;
                y = y - dy;
                z = z + longint'(ATAN_Q30[i]);
            end
        end
        case (quad)
            0: c = x;
            1: c = -y;
            2: c = -x;
            default: c = y;
        endcase
        return round_shift(c, 10);
    endfunction

    // Advances the car copy by one request and returns the result it gives.
    function automatic car_result_t advance_car(logic rtype, logic [1:0] act,
                                                logic signed [23:0] start);
        car_result_t o;
        longint v, p, factor, rew, two;
        logic refused;
        rew = 0;
        refused = 1'b0;
        factor = longint'(1) <<< 20;
        if (rtype == REQ_RESTART)
        begin
            car_pos = bound(longint'(start), cfg_left, cfg_right);
            car_vel = 0;
            ep_done = 1'b0;
            ep_sum = 0;
        end
        else if (ep_done)
        begin
            refused = 1'b1;
        end
        else
        begin
            v = car_vel;
            p = car_pos;
            if (act == ACT_LEFT)
            begin
                v = v - cfg_push;
            end
            else if (act == ACT_RIGHT)
            begin
                v = v + cfg_push;
            end
            v = v - round_shift(cfg_gain * cos_three(p), 20);
            case (cfg_friction)
                FRIC_LOW:  factor = (99 * factor + 50) / 100;
                FRIC_MED:  factor = (197 * factor + 100) / 200;
                FRIC_HIGH: factor = (39 * factor + 20) / 40;
                default:   factor = factor;
            endcase
            if (cfg_friction != FRIC_NONE)
            begin
                v = round_shift(v * factor, 20);
            end
            v = bound(v, -cfg_speed, cfg_speed);
            p = bound(p + v, cfg_left, cfg_right);
            if (p == cfg_left && v < 0)
            begin
                v = 0;
            end
            car_pos = p;
            car_vel = v;
            ep_done = (p >= cfg_goal);
            if (!ep_done)
            begin
                rew = -1;
                if (ep_sum > -1048575)
                begin
                    ep_sum = ep_sum - 1;
                end
            end
        end
        two = longint'(2) <<< 20;
        o.position = car_pos[23:0];
        o.velocity = car_vel[21:0];
        o.norm_pos = 23'(bound(div_nearest(10 * car_pos + (longint'(3) <<< 20), 9), -two, two));
        o.norm_vel = 23'(bound(div_nearest(100 * car_vel, 7), -two, two));
        o.reward   = rew[0:0];
        o.total    = ep_sum[20:0];
        o.done     = ep_done;
        o.refused  = refused;
        return o;
    endfunction

    function automatic int field_differs(string name, longint want, longint got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            return 1;
        end
        return 0;
    endfunction

    assign pending = expected_results.size();

    always @(posedge clk or negedge rst_n)
    begin
        car_result_t w, g;
        int bad;
        if (!rst_n)
        begin
            cfg_friction  = FRIC_NONE;
            cfg_push      = 1049;
            cfg_gain      = 2621;
            cfg_speed     = 73400;
            cfg_left      = -1258291;
            cfg_right     = 629146;
            cfg_goal      = 524288;
            car_pos       = 0;
            car_vel       = 0;
            ep_sum        = 0;
            ep_done       = 1'b0;
            fail_count    = 0;
            steps_seen    = 0;
            goals_seen    = 0;
            refusals_seen = 0;
            expected_results.delete();
        end
        else
        begin
            // Register writes take effect at the access edge.
            if (psel && penable && pwrite && pready && paddr[1:0] == 2'b00)
            begin
                case (paddr[4:2])
                    REG_FRICTION: cfg_friction = pwdata[1:0];
                    REG_PUSH:     cfg_push  = longint'(pwdata[15:0]);
                    REG_GAIN:     cfg_gain  = longint'(pwdata[15:0]);
                    REG_SPEED:    cfg_speed = longint'(pwdata[20:0]);
                    REG_LEFT:     cfg_left  = longint'(signed'(pwdata[22:0]));
                    REG_RIGHT:    cfg_right = longint'(pwdata[22:0]);
                    REG_GOAL:     cfg_goal  = longint'(signed'(pwdata[23:0]));
                    default:      ;
                endcase
            end

            // Result beat: compare with the oldest prediction.
            if (res.valid && res.ready)
            begin
                g.position = res.position_out;
                g.velocity = res.velocity_out;
                g.norm_pos = res.norm_position;
                g.norm_vel = res.norm_velocity;
                g.reward   = res.reward;
                g.total    = res.reward_total;
                g.done     = res.done_res;
                g.refused  = res.step_error;
                if (expected_results.size() == 0)
                begin
                    $error("result beat with no request outstanding");
                    fail_count++;
                end
                else
                begin
                    w = expected_results.pop_front();
                    bad = 0;
                    bad += field_differs("position_out", w.position, g.position);
                    bad += field_differs("velocity_out", w.velocity, g.velocity);
                    bad += field_differs("norm_position", w.norm_pos, g.norm_pos);
                    bad += field_differs("norm_velocity", w.norm_vel, g.norm_vel);
                    bad += field_differs("reward", w.reward, g.reward);
                    bad += field_differs("reward_total", w.total, g.total);
                    bad += field_differs("done_res", w.done, g.done);
                    bad += field_differs("step_error", w.refused, g.refused);
                    if (bad != 0)
                    begin
                        fail_count++;
                    end
                end
            end

            // Request beat: predict its result.
            if (req.valid && req.ready)
            begin
                w = advance_car(req.req_type, req.action, req.start_position);
                expected_results.push_back(w);
                if (req.req_type == REQ_STEP)
                begin
                    steps_seen++;
                end
                if (w.refused)
                begin
                    refusals_seen++;
                end
                else if (req.req_type == REQ_STEP && w.done)
                begin
                    goals_seen++;
                end
            end
        end
    end

endmodule

// ===== tb/sv/tb_mountain_car_physics_step.sv =====
`timescale 1ns / 1ps

// Drives requests and register writes into the step engine through several
// configurations and idling phases, and gives the verdict.
module tb_mountain_car_physics_step;
    import mcps_pkg::*;

    localparam int CYCLE_LIMIT = 2000000;

    logic        clk;
    logic        rst_n;
    logic        psel, penable, pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int fail_count, pending, steps_seen, goals_seen, refusals_seen;
    int idle_mode;
    int items_sent;
    int cycle_count;

    mcps_req_if req ();
    mcps_res_if res ();

    mountain_car_physics_step uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .res     (res),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    mcps_checker car_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .req           (req),
        .res           (res),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .pready        (pready),
        .fail_count    (fail_count),
        .pending       (pending),
        .steps_seen    (steps_seen),
        .goals_seen    (goals_seen),
        .refusals_seen (refusals_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // Watchdog on the whole run.
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("timeout after %0d cycles", cycle_count);
                $display("** mountain_car_physics_step: FAILED **");
                $finish;
            end
        end
    end

    // Result side stalls according to the current phase.
    always @(negedge clk)
    begin
        if (idle_mode == 2)
        begin
            res.ready <= ($urandom_range(99) >= 47);
        end
        else if (idle_mode == 3)
        begin
            res.ready <= ($urandom_range(99) >= 24);
        end
        else
        begin
            res.ready <= 1'b1;
        end
    end

    task automatic reg_write(reg_index_t idx, logic [31:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // One request beat; the sender may idle first.
    task automatic send_request(logic rtype, logic [1:0] act, logic [23:0] start);
        int gap_pct;
        gap_pct = (idle_mode == 1) ? 47 : ((idle_mode == 3) ? 24 : 0);
        @(negedge clk);
        while ($urandom_range(99) < gap_pct)
        begin
            req.valid <= 1'b0;
            @(negedge clk);
        end
        req.valid          <= 1'b1;
        req.req_type       <= rtype;
        req.action         <= act;
        req.start_position <= start;
        do
        begin
            @(posedge clk);
        end
        while (!req.ready);
        @(negedge clk);
        req.valid <= 1'b0;
        items_sent++;
    endtask

    // Lets every outstanding result drain before registers change.
    task automatic drain;
        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (40) @(posedge clk);
    endtask

    task automatic load_config(logic [1:0] fr, logic [31:0] push, logic [31:0] gain,
                               logic [31:0] speed, logic [31:0] left,
                               logic [31:0] right, logic [31:0] goal);
        drain();
        reg_write(REG_FRICTION, {30'd0, fr});
        reg_write(REG_PUSH, push);
        reg_write(REG_GAIN, gain);
        reg_write(REG_SPEED, speed);
        reg_write(REG_LEFT, left);
        reg_write(REG_RIGHT, right);
        reg_write(REG_GOAL, goal);
    endtask

    function automatic logic [23:0] pick_start();
        int sel;
        sel = $urandom_range(9);
        if (sel == 0)
        begin
            return 24'($urandom());
        end
        else if (sel == 1)
        begin
            return 24'(-4194304);
        end
        else if (sel == 2)
        begin
            return 24'd4194304;
        end
        return 24'($signed($urandom_range(8388608)) - 4194304);
    endfunction

    // Episodes: a restart followed by a run of steps, with some noise.
    task automatic random_episodes(int count, bit pause_once);
        int target, n, style;
        logic [1:0] act;
        target = items_sent + count;
        while (items_sent < target)
        begin
            if ($urandom_range(9) != 0)
            begin
                send_request(REQ_RESTART, 2'($urandom()), pick_start());
            end
            n = $urandom_range(1, 40);
            style = $urandom_range(3);
            for (int i = 0; i < n && items_sent < target; i++)
            begin
                if (style == 0)
                begin
                    act = ACT_RIGHT;
                end
                else if (style == 1)
                begin
                    act = (i % 20 < 10) ? ACT_LEFT : ACT_RIGHT;
                end
                else
                begin
                    act = 2'($urandom());
                end
                send_request(REQ_STEP, act, 24'($urandom()));
            end
            if (pause_once && items_sent > target - count / 2)
            begin
                drain();
                pause_once = 0;
            end
        end
    endtask

    initial
    begin
        rst_n              = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        req.valid          = 1'b0;
        req.req_type       = REQ_STEP;
        req.action         = ACT_LEFT;
        req.start_position = '0;
        res.ready          = 1'b1;
        idle_mode          = 0;
        items_sent         = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part under the reset configuration.
        send_request(REQ_STEP, ACT_RIGHT, 24'd0);
        send_request(REQ_STEP, 2'd3, 24'hFFFFFF);
        send_request(REQ_RESTART, ACT_LEFT, 24'(-4194304));
        send_request(REQ_STEP, ACT_LEFT, 24'd0);
        send_request(REQ_STEP, ACT_LEFT, 24'd0);
        send_request(REQ_RESTART, ACT_LEFT, 24'd4194304);
        send_request(REQ_STEP, 2'd1, 24'd0);
        send_request(REQ_STEP, ACT_RIGHT, 24'd0);
        send_request(REQ_RESTART, ACT_RIGHT, 24'h7FFFFF);
        send_request(REQ_RESTART, ACT_RIGHT, 24'h800000);
        send_request(REQ_RESTART, ACT_RIGHT, 24'd520000);
        repeat (4) send_request(REQ_STEP, ACT_RIGHT, 24'd0);
        send_request(REQ_STEP, 2'd3, 24'd0);
        send_request(REQ_RESTART, ACT_LEFT, 24'(-300000));
        send_request(REQ_STEP, 2'd3, 24'd0);

        // Configuration phases, rotating through the idling patterns.
        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0: ;
                1: load_config(FRIC_LOW, 32'hFFFF, 32'h0, 32'h100000, 32'hFFC00000,
                               32'h400000, 32'h400000);
                2: load_config(FRIC_MED, 32'h0, 32'hFFFF, 32'h0, 32'h0, 32'h0,
                               32'hFFC00000);
                3: load_config(FRIC_HIGH, 32'd20000, 32'd2621, 32'd73400,
                               32'(-1258291), 32'd629146, 32'd0);
                // Crossed limits: the left wall sits right of the right limit.
                4: load_config(FRIC_NONE, 32'd5000, 32'd2621, 32'd73400, 32'hF0100000,
                               32'h80000, 32'h90000);
                5:
                begin
                    load_config(2'($urandom()), $urandom(), $urandom(), $urandom(),
                                $urandom(), $urandom(), $urandom());
                    reg_write(reg_index_t'(3'd7), $urandom());
                end
                6: load_config(FRIC_LOW, 32'd8000, 32'd2621, 32'd73400, 32'(-1258291),
                               32'd629146, 32'd300000);
                default: load_config(FRIC_NONE, 32'd1049, 32'd2621, 32'd73400,
                                     32'(-1258291), 32'd629146, 32'd524288);
            endcase
            idle_mode = ph % 4;
            random_episodes(130, ph == 1);
        end

        drain();
        $display("%0d requests sent, %0d of them steps; %0d goals reached, %0d refused steps",
                 items_sent, steps_seen, goals_seen, refusals_seen);
        $display("eight register settings, four idling patterns, crossed limits included");
        if (fail_count == 0)
        begin
            $display("** mountain_car_physics_step: PASSED **");
        end
        else
        begin
            $display("** mountain_car_physics_step: FAILED **");
        end
        $finish;
    end

endmodule
